@@ rtl/jfpr_pkg.sv @@
// Shared constants, codes and control structs of the five-point relaxation unit.
package jfpr_pkg;

    localparam int GRID_SIZE = 16;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W    = $clog2(CELLS);

    localparam int VAL_W  = 26;
    localparam int FRAC_W = 16;
    localparam int LOAD_W = 10;
    localparam int CNT_W  = 16;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int CMD_W  = 2;

    // A sum of five cell values needs three more bits than one value.
    localparam int SUM_W = VAL_W + 3;

    // Division by five as a multiply by ceil(2^32 / 5) and a shift by 32.
    // The rounding error stays below one tenth for sums under 2^29.
    localparam int                 RECIP_W     = 30;
    localparam int                 RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP5      = 30'd858993460;

    localparam logic [VAL_W-1:0] TOL_RESET        = 26'd655;
    localparam logic [CNT_W-1:0] MAX_SWEEPS_RESET = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic acc_add;    // add the returned read data into the sum
        logic acc_first;  // first term of a cell: restart the sum, keep the center
        logic term_ok;    // returned data is a real neighbor, not the zero border
        logic mul;        // register the mean of the sum
        logic max_upd;    // fold the change of this cell into the largest change
        logic max_first;  // first cell of a sweep
    } t_alu_ctrl;

    typedef struct packed {
        logic              we0;
        logic              we1;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
        logic              rd_bank;
    } t_mem_ctrl;

    typedef struct packed {
        logic             rd_strobe;
        logic             rd_inside;
        logic             sol_strobe;
        logic             converged;
        logic [CNT_W-1:0] sweeps;
    } t_seq_stat;

endpackage

@@ rtl/jfpr_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module jfpr_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/jfpr_alu.sv @@
// Shared arithmetic: five-term accumulation, mean by reciprocal, change and its maximum.
module jfpr_alu
    import jfpr_pkg::*;
(
    input  logic             i_clk,
    input  t_alu_ctrl        i_ctrl,
    input  logic [VAL_W-1:0] i_rd_data,
    output logic [VAL_W-1:0] o_mean,
    output logic [VAL_W-1:0] o_largest
);

    logic [SUM_W-1:0]         r_sum;
    logic [VAL_W-1:0]         r_center;
    logic [VAL_W-1:0]         r_mean;
    logic [VAL_W-1:0]         r_max;
    logic [SUM_W-1:0]         term;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [VAL_W-1:0]         diff;

    assign term = i_ctrl.term_ok ? SUM_W'(i_rd_data) : '0;
    assign prod = r_sum * RECIP5;
    assign diff = (r_mean > r_center) ? (r_mean - r_center) : (r_center - r_mean);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_add) begin
            if (i_ctrl.acc_first) begin
                r_sum    <= term;
                r_center <= i_rd_data;
            end else begin
                r_sum <= r_sum + term;
            end
        end
        if (i_ctrl.mul) begin
            r_mean <= prod[RECIP_SHIFT +: VAL_W];
        end
        if (i_ctrl.max_upd) begin
            if (i_ctrl.max_first || (diff > r_max)) begin
                r_max <= diff;
            end
        end
    end

    assign o_mean    = r_mean;
    assign o_largest = r_max;

endmodule

@@ rtl/jfpr_seq.sv @@
// Sequencer: command decode, grid walk, neighbor fetch order and sweep control.
module jfpr_seq
    import jfpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_column,
    input  logic [LOAD_W-1:0] i_load_value,
    input  logic [VAL_W-1:0]  i_tolerance,
    input  logic [CNT_W-1:0]  i_max_sweeps,
    input  logic [VAL_W-1:0]  i_mean,
    input  logic [VAL_W-1:0]  i_largest,
    output logic              o_busy,
    output t_alu_ctrl         o_alu,
    output t_mem_ctrl         o_mem,
    output t_seq_stat         o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_MUL,
        S_WRITE,
        S_END
    } t_state;

    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_LEFT   = 3'd1;
    localparam logic [2:0] NB_RIGHT  = 3'd2;
    localparam logic [2:0] NB_UP     = 3'd3;
    localparam logic [2:0] NB_DOWN   = 3'd4;

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(GRID_SIZE - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

    t_state             r_state, n_state;
    logic [2:0]         r_k, n_k;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_nb_ok, n_nb_ok;
    logic               r_sel, n_sel;
    logic [CNT_W-1:0]   r_sweeps, n_sweeps;
    logic               r_conv, n_conv;
    logic               r_sol_strobe, n_sol_strobe;
    logic               r_rd_strobe, n_rd_strobe;
    logic               r_rd_inside, n_rd_inside;

    logic               in_inside;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  nb_addr;
    logic               nb_ok;
    logic [CNT_W-1:0]   sweeps_inc;

    assign in_inside = (int'(i_row) < GRID_SIZE) && (int'(i_column) < GRID_SIZE);
    assign in_addr   = ADDR_W'(int'(IDX_W'(i_row)) * GRID_SIZE + int'(IDX_W'(i_column)));
    assign sweeps_inc = r_sweeps + CNT_W'(1);

    // Address of the neighbor fetched in this step; cells beyond the edge count as zero.
    always_comb begin
        case (r_k)
            NB_CENTER: begin
                nb_addr = r_addr;
                nb_ok   = 1'b1;
            end
            NB_LEFT: begin
                nb_addr = r_addr - ADDR_W'(1);
                nb_ok   = (r_col != '0);
            end
            NB_RIGHT: begin
                nb_addr = r_addr + ADDR_W'(1);
                nb_ok   = (r_col != IDX_LAST);
            end
            NB_UP: begin
                nb_addr = r_addr - ADDR_W'(GRID_SIZE);
                nb_ok   = (r_row != '0);
            end
            NB_DOWN: begin
                nb_addr = r_addr + ADDR_W'(GRID_SIZE);
                nb_ok   = (r_row != IDX_LAST);
            end
            default: begin
                nb_addr = r_addr;
                nb_ok   = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_row        = r_row;
        n_col        = r_col;
        n_addr       = r_addr;
        n_nb_ok      = r_nb_ok;
        n_sel        = r_sel;
        n_sweeps     = r_sweeps;
        n_conv       = r_conv;
        n_rd_inside  = r_rd_inside;
        n_sol_strobe = 1'b0;
        n_rd_strobe  = 1'b0;

        o_alu = '0;

        o_mem.we0     = 1'b0;
        o_mem.we1     = 1'b0;
        o_mem.waddr   = in_addr;
        o_mem.wdata   = VAL_W'({i_load_value, {FRAC_W{1'b0}}});
        o_mem.raddr   = in_addr;
        o_mem.rd_bank = r_sel;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            if (in_inside) begin
                                o_mem.we0 = ~r_sel;
                                o_mem.we1 = r_sel;
                            end
                        end
                        CMD_READ: begin
                            n_rd_strobe = 1'b1;
                            n_rd_inside = in_inside;
                        end
                        CMD_SOLVE: begin
                            n_row    = '0;
                            n_col    = '0;
                            n_addr   = '0;
                            n_k      = NB_CENTER;
                            n_sweeps = '0;
                            n_state  = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_mem.raddr = nb_addr;
                n_nb_ok     = nb_ok;
                // Data of the previous step returns now.
                if (r_k != NB_CENTER) begin
                    o_alu.acc_add   = 1'b1;
                    o_alu.acc_first = (r_k == NB_LEFT);
                    o_alu.term_ok   = r_nb_ok;
                end
                if (r_k == NB_DOWN) begin
                    n_state = S_ACC;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_ACC: begin
                o_alu.acc_add = 1'b1;
                o_alu.term_ok = r_nb_ok;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_alu.mul = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                o_mem.we0       = r_sel;
                o_mem.we1       = ~r_sel;
                o_mem.waddr     = r_addr;
                o_mem.wdata     = i_mean;
                o_alu.max_upd   = 1'b1;
                o_alu.max_first = (r_addr == '0);
                n_k             = NB_CENTER;
                if (r_addr == ADDR_LAST) begin
                    n_state = S_END;
                end else begin
                    n_addr  = r_addr + ADDR_W'(1);
                    n_state = S_READ;
                    if (r_col == IDX_LAST) begin
                        n_col = '0;
                        n_row = r_row + IDX_W'(1);
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                end
            end
            S_END: begin
                n_sweeps = sweeps_inc;
                n_row    = '0;
                n_col    = '0;
                n_addr   = '0;
                if (i_largest < i_tolerance) begin
                    // Converged: the new grid is dropped and the old bank stays current.
                    n_conv       = 1'b1;
                    n_sol_strobe = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_sel = ~r_sel;
                    if (sweeps_inc >= i_max_sweeps) begin
                        n_conv       = 1'b0;
                        n_sol_strobe = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_k          <= NB_CENTER;
            r_row        <= '0;
            r_col        <= '0;
            r_addr       <= '0;
            r_nb_ok      <= 1'b0;
            r_sel        <= 1'b0;
            r_sweeps     <= '0;
            r_conv       <= 1'b0;
            r_sol_strobe <= 1'b0;
            r_rd_strobe  <= 1'b0;
            r_rd_inside  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_row        <= n_row;
            r_col        <= n_col;
            r_addr       <= n_addr;
            r_nb_ok      <= n_nb_ok;
            r_sel        <= n_sel;
            r_sweeps     <= n_sweeps;
            r_conv       <= n_conv;
            r_sol_strobe <= n_sol_strobe;
            r_rd_strobe  <= n_rd_strobe;
            r_rd_inside  <= n_rd_inside;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    assign o_stat.rd_strobe  = r_rd_strobe;
    assign o_stat.rd_inside  = r_rd_inside;
    assign o_stat.sol_strobe = r_sol_strobe;
    assign o_stat.converged  = r_conv;
    assign o_stat.sweeps     = r_sweeps;

endmodule

@@ rtl/jacobi_five_point_relaxation_unit.sv @@
// Top level of the five-point Jacobi relaxation unit: register port, grid banks, result ports.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------------------
//  command   i_start, o_busy              i_command, i_row, i_column, i_load_value
//  result    o_strobe (one cycle)         o_result_kind, o_cell_value, o_sweep_count,
//                                         o_converged
//  config    psel, penable, pwrite,       paddr, pwdata, prdata
//            pready (always high)
//
// Load and read beats are taken every cycle while o_busy is low; read data appears in
// the cycle after the beat. A solve keeps o_busy high for all its sweeps: each cell
// fetches its five terms one at a time through the single read port of the current
// grid bank, then takes an accumulate, a multiply and a write step, and each sweep
// ends with a decision step. o_busy rises in the cycle after the solve beat.
// The status beat comes in the cycle after the last sweep. Reset is synchronous and
// active low and needs no clearing pass. Results cannot be stalled by the receiver.
module jacobi_five_point_relaxation_unit
    import jfpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_column,
    input  logic [LOAD_W-1:0] i_load_value,
    output logic              o_strobe,
    output logic              o_result_kind,
    output logic [VAL_W-1:0]  o_cell_value,
    output logic [CNT_W-1:0]  o_sweep_count,
    output logic              o_converged,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_MAX_SWEEPS = 1'b1;

    logic [VAL_W-1:0] r_tolerance;
    logic [CNT_W-1:0] r_max_sweeps;
    logic             cfg_write;

    t_alu_ctrl        alu_ctrl;
    t_mem_ctrl        mem_ctrl;
    t_seq_stat        stat;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] largest;
    logic [VAL_W-1:0] rdata0;
    logic [VAL_W-1:0] rdata1;
    logic [VAL_W-1:0] rd_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= TOL_RESET;
            r_max_sweeps <= MAX_SWEEPS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_TOLERANCE:  r_tolerance  <= pwdata[VAL_W-1:0];
                REG_MAX_SWEEPS: r_max_sweeps <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TOLERANCE:  prdata = 32'(r_tolerance);
            REG_MAX_SWEEPS: prdata = 32'(r_max_sweeps);
            default:        prdata = '0;
        endcase
    end

    jfpr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_load_value (i_load_value),
        .i_tolerance  (r_tolerance),
        .i_max_sweeps (r_max_sweeps),
        .i_mean       (mean),
        .i_largest    (largest),
        .o_busy       (o_busy),
        .o_alu        (alu_ctrl),
        .o_mem        (mem_ctrl),
        .o_stat       (stat)
    );

    jfpr_alu u_alu (
        .i_clk     (i_clk),
        .i_ctrl    (alu_ctrl),
        .i_rd_data (rd_data),
        .o_mean    (mean),
        .o_largest (largest)
    );

    // Two grid banks; the sequencer swaps which one is current when a sweep commits.
    jfpr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELLS)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (mem_ctrl.we0),
        .i_waddr (mem_ctrl.waddr),
        .i_wdata (mem_ctrl.wdata),
        .i_raddr (mem_ctrl.raddr),
        .o_rdata (rdata0)
    );

    jfpr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELLS)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (mem_ctrl.we1),
        .i_waddr (mem_ctrl.waddr),
        .i_wdata (mem_ctrl.wdata),
        .i_raddr (mem_ctrl.raddr),
        .o_rdata (rdata1)
    );

    assign rd_data = mem_ctrl.rd_bank ? rdata1 : rdata0;

    assign o_strobe      = stat.rd_strobe || stat.sol_strobe;
    assign o_result_kind = stat.sol_strobe;
    assign o_cell_value  = (stat.rd_strobe && stat.rd_inside) ? rd_data : '0;
    assign o_sweep_count = stat.sol_strobe ? stat.sweeps : '0;
    assign o_converged   = stat.sol_strobe && stat.converged;

endmodule
